>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the keyed slot table.
// Every property is sampled on the rising edge of clk_i and is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kst_pkg.sv
package kst_pkg;

  // Request types.
  localparam logic [1:0] REQ_CLAIM      = 2'd0;
  localparam logic [1:0] REQ_CONNECT    = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;
  localparam logic [1:0] REQ_MOVE       = 2'd3;

  // Status codes of a response.
  localparam logic [2:0] STS_UPDATED  = 3'd0;
  localparam logic [2:0] STS_INSERTED = 3'd1;
  localparam logic [2:0] STS_REMOVED  = 3'd2;
  localparam logic [2:0] STS_MISS     = 3'd3;
  localparam logic [2:0] STS_OWN      = 3'd4;

  localparam int unsigned KeyWidth  = 31;
  localparam int unsigned PosWidth  = 16;
  localparam int unsigned SlotWidth = 5;

  // One request.
  typedef struct packed {
    logic [1:0]                 req_type;
    logic [KeyWidth-1:0]        player_key;
    logic signed [PosWidth-1:0] pos_x;
    logic signed [PosWidth-1:0] pos_y;
  } kst_req_t;

  // One response.
  typedef struct packed {
    logic [2:0]           status;
    logic [SlotWidth-1:0] slot_index;
  } kst_rsp_t;

  // One slot as it is held in the table memory.
  typedef struct packed {
    logic                       valid;
    logic [KeyWidth-1:0]        key;
    logic signed [PosWidth-1:0] pos_x;
    logic signed [PosWidth-1:0] pos_y;
  } kst_entry_t;

endpackage

>>> rtl/keyed_slot_table_top.sv
// Keyed slot table: SLOT_COUNT slots, each holding a valid mark, a key and an x,y position,
// kept together in one memory word. After reset the block is busy while it clears every
// slot, one per cycle. A request is taken when start is high and busy is low. The block
// then reads the slots in order through the single memory read port and tests each one
// with a single key comparator, one slot per cycle, stopping at the first slot that decides
// the request. A request keeps busy high while its scan runs, at worst through every slot,
// and its response appears in the cycle busy falls, so a new request can be taken in that
// same cycle. A move naming the block's own key is answered in the cycle after it is taken,
// without a scan. Each response is shown for exactly one cycle with done_o high and cannot
// be held off by the receiver. slot_index carries the low five bits of the slot number.
`include "assert_macros.svh"

module keyed_slot_table_top #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  kst_pkg::kst_req_t req_i,
  output logic              done_o,
  output kst_pkg::kst_rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(SLOT_COUNT);
  localparam int unsigned EW = $bits(kst_pkg::kst_entry_t);

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [AW-1:0]                    idx_q, idx_d;
  kst_pkg::kst_req_t                req_q, req_d;
  logic [kst_pkg::KeyWidth-1:0]     own_key_q, own_key_d;
  logic                             done_q, done_d;
  kst_pkg::kst_rsp_t                rsp_q, rsp_d;

  logic                             ram_we;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  kst_pkg::kst_entry_t              ram_wdata;
  logic [EW-1:0]                    ram_rdata;
  kst_pkg::kst_entry_t              rd_entry;

  logic                             key_eq;
  logic                             hit;
  logic                             free_slot;
  logic                             own_move;
  logic                             last_slot;
  logic                             found;
  logic [2:0]                       found_sts;

  // Table memory: one word per slot.
  kst_ram #(
    .WIDTH(EW),
    .DEPTH(SLOT_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = kst_pkg::kst_entry_t'(ram_rdata);

  // One key comparator serves the scan; the own-key test has its own comparator, used only at acceptance.
  assign key_eq    = (rd_entry.key == req_q.player_key);
  assign hit       = rd_entry.valid && key_eq;
  assign free_slot = !rd_entry.valid;
  assign own_move  = (req_i.req_type == kst_pkg::REQ_MOVE) && (req_i.player_key == own_key_q);
  assign last_slot = (idx_q == AW'(SLOT_COUNT - 1));

  // Decision for the slot whose word is on the read data this cycle.
  always_comb begin
    found     = 1'b0;
    found_sts = kst_pkg::STS_MISS;
    ram_wdata = rd_entry;
    case (req_q.req_type)
      kst_pkg::REQ_CLAIM: begin
        if (free_slot) begin
          found           = 1'b1;
          found_sts       = kst_pkg::STS_INSERTED;
          ram_wdata.valid = 1'b1;
          ram_wdata.key   = req_q.player_key;
        end
      end
      kst_pkg::REQ_CONNECT: begin
        if (hit || free_slot) begin
          found     = 1'b1;
          found_sts = hit ? kst_pkg::STS_UPDATED : kst_pkg::STS_INSERTED;
          ram_wdata = '{valid: 1'b1, key: req_q.player_key,
                        pos_x: req_q.pos_x, pos_y: req_q.pos_y};
        end
      end
      kst_pkg::REQ_DISCONNECT: begin
        if (hit) begin
          found           = 1'b1;
          found_sts       = kst_pkg::STS_REMOVED;
          ram_wdata.valid = 1'b0;
        end
      end
      kst_pkg::REQ_MOVE: begin
        if (hit) begin
          found     = 1'b1;
          found_sts = kst_pkg::STS_UPDATED;
          ram_wdata = '{valid: 1'b1, key: req_q.player_key,
                        pos_x: req_q.pos_x, pos_y: req_q.pos_y};
        end
      end
      default: begin
        found = 1'b0;
      end
    endcase
    // The clearing pass writes an all-zero word, which marks the slot free.
    if (state_q == ST_CLEAR) begin
      ram_wdata = '0;
    end
  end

  // Sequencer: clear after reset, then one slot per cycle for each request; own-key moves skip the scan.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    req_d     = req_q;
    own_key_d = own_key_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q + AW'(1);
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (last_slot) begin
          state_d = ST_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (own_move) begin
            done_d = 1'b1;
            rsp_d  = '{status: kst_pkg::STS_OWN, slot_index: '0};
          end else begin
            req_d     = req_i;
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          ram_we  = 1'b1;
          done_d  = 1'b1;
          rsp_d   = '{status: found_sts, slot_index: kst_pkg::SlotWidth'(idx_q)};
          state_d = ST_IDLE;
          if (req_q.req_type == kst_pkg::REQ_CLAIM) begin
            own_key_d = req_q.player_key;
          end
        end else if (last_slot) begin
          done_d  = 1'b1;
          rsp_d   = '{status: kst_pkg::STS_MISS, slot_index: '0};
          state_d = ST_IDLE;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      own_key_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      own_key_q <= own_key_d;
      done_q    <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `KST_ASSERT_SAME(a_miss_slot_zero,
                   done_o && (rsp_o.status == kst_pkg::STS_MISS ||
                              rsp_o.status == kst_pkg::STS_OWN),
                   rsp_o.slot_index == '0, "miss or own-key response with non-zero slot")
  `KST_ASSERT_NEXT(a_scan_starts, start && !busy && !own_move, busy,
                   "accepted request did not start a scan")
  `KST_ASSERT_SAME(a_done_idle, done_o, !busy, "response shown while still busy")

endmodule

>>> rtl/kst_ram.sv
// Simple dual-port RAM: one write port and one read port with registered read data.
module kst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data appears in the following cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
